FILE: rtl/tsjt_pkg.sv
package tsjt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int OUT_CNT_W = 5;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_PURGE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REPLACED = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_PURGED = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] due_time;
        logic [7:0]  service_id;
        logic [7:0]  function_id;
        logic [15:0] job_tag;
    } job_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [4:0]  removed_count;
        logic        head_valid;
        logic [31:0] head_time;
        logic [15:0] head_tag;
    } job_rsp_t;

    typedef struct packed {
        logic [31:0] due_time;
        logic [7:0]  service_id;
        logic [7:0]  function_id;
        logic [15:0] job_tag;
    } job_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     any_match;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_PURGE,
        ST_FINISH
    } tsjt_state_t;

endpackage

FILE: rtl/tsjt_cell.sv
module tsjt_cell
    import tsjt_pkg::*;
(
    input  logic       aclk,
    input  cell_ctl_t  ctl,
    input  job_entry_t new_entry,
    input  job_entry_t left_entry,
    input  job_entry_t right_entry,
    input  logic       left_after,
    input  logic       occupied,
    output job_entry_t entry,
    output logic       match,
    output logic       after
);

    job_entry_t entry_reg;
    job_entry_t entry_next;

    assign entry = entry_reg;

    // A free slot counts as lying after the insertion point, so the chain
    // of after flags is monotonic along the row.
    assign match = occupied && (entry_reg.due_time == new_entry.due_time)
                   && (entry_reg.service_id == new_entry.service_id)
                   && (entry_reg.function_id == new_entry.function_id);
    assign after = !occupied || (entry_reg.due_time >= new_entry.due_time);

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.op)
            CELL_ADD: begin
                if (ctl.any_match) begin
                    if (match) begin
                        entry_next = new_entry;
                    end
                end else if (left_after) begin
                    entry_next = left_entry;
                end else if (after) begin
                    entry_next = new_entry;
                end
            end
            CELL_SHIFT: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/time_sorted_job_table.sv
// Job table kept sorted by due time, earliest first, in a row of entry
// cells that compare against the request in parallel and shift data to their
// neighbors. An add is accepted in the idle state, updates the row in the add
// state and loads its result in the finish state, where the next request may
// already be taken once the output register is free. A purge moves the row
// one place to the left per cycle for each removed entry. One request is in
// work at a time, and a finished result may wait in the output register while
// the next request is accepted and processed.
module time_sorted_job_table
    import tsjt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  job_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output job_rsp_t m_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    tsjt_state_t state_reg;
    tsjt_state_t state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] removed_reg;
    logic [CNT_W-1:0] removed_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    job_req_t req_reg;
    logic m_valid_reg;
    job_rsp_t m_data_reg;

    cell_ctl_t ctl;
    job_entry_t new_entry;
    job_entry_t cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_match;
    logic [TABLE_DEPTH-1:0] cell_after;
    logic [TABLE_DEPTH-1:0] cell_occ;

    logic accept;
    logic out_free;
    logic out_load;
    logic any_match;
    logic full;
    logic [CNT_W+OUT_CNT_W-1:0] count_wide;
    logic [CNT_W+OUT_CNT_W-1:0] removed_wide;
    job_rsp_t rsp;

    assign new_entry.due_time = req_reg.due_time;
    assign new_entry.service_id = req_reg.service_id;
    assign new_entry.function_id = req_reg.function_id;
    assign new_entry.job_tag = req_reg.job_tag;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            assign cell_occ[gi] = CNT_W'(gi) < count_reg;
            if (gi == 0) begin : g_first
                tsjt_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl),
                    .new_entry   (new_entry),
                    .left_entry  (new_entry),
                    .right_entry (cell_entry[gi+1]),
                    .left_after  (1'b0),
                    .occupied    (cell_occ[gi]),
                    .entry       (cell_entry[gi]),
                    .match       (cell_match[gi]),
                    .after       (cell_after[gi])
                );
            end else if (gi == TABLE_DEPTH - 1) begin : g_last
                tsjt_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl),
                    .new_entry   (new_entry),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi]),
                    .left_after  (cell_after[gi-1]),
                    .occupied    (cell_occ[gi]),
                    .entry       (cell_entry[gi]),
                    .match       (cell_match[gi]),
                    .after       (cell_after[gi])
                );
            end else begin : g_mid
                tsjt_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl),
                    .new_entry   (new_entry),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi+1]),
                    .left_after  (cell_after[gi-1]),
                    .occupied    (cell_occ[gi]),
                    .entry       (cell_entry[gi]),
                    .match       (cell_match[gi]),
                    .after       (cell_after[gi])
                );
            end
        end
    endgenerate

    assign any_match = |cell_match;
    assign full = count_reg == CNT_W'(TABLE_DEPTH);
    assign out_free = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        removed_next = removed_reg;
        status_next = status_reg;
        ctl.op = CELL_HOLD;
        ctl.any_match = any_match;
        s_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_ADD: begin
                if (any_match) begin
                    ctl.op = CELL_ADD;
                    status_next = STATUS_REPLACED;
                end else if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ctl.op = CELL_ADD;
                    status_next = STATUS_INSERTED;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_FINISH;
            end
            ST_PURGE: begin
                status_next = STATUS_PURGED;
                if (cell_occ[0] && (cell_entry[0].due_time <= req_reg.due_time)) begin
                    ctl.op = CELL_SHIFT;
                    count_next = count_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    s_ready = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept) begin
            removed_next = '0;
            state_next = (s_data.action == ACT_PURGE) ? ST_PURGE : ST_ADD;
        end
    end

    assign count_wide = {{OUT_CNT_W{1'b0}}, count_reg};
    assign removed_wide = {{OUT_CNT_W{1'b0}}, removed_reg};

    always_comb begin
        rsp.status = status_reg;
        rsp.entry_count = count_wide[OUT_CNT_W-1:0];
        rsp.head_valid = cell_occ[0];
        rsp.head_time = cell_occ[0] ? cell_entry[0].due_time : '0;
        rsp.head_tag = cell_occ[0] ? cell_entry[0].job_tag : '0;
        rsp.removed_count = (status_reg == STATUS_PURGED) ?
                            removed_wide[OUT_CNT_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        removed_reg <= removed_next;
        status_reg <= status_next;
        if (accept) begin
            req_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

FILE: rtl/tsjt_checker.sv
module tsjt_checker
    import tsjt_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input job_req_t s_data,
    input logic     m_valid,
    input logic     m_ready,
    input job_rsp_t m_data
);

    // A result that is not taken stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result transfer changed while stalled.");

    // The head entry is reported exactly when the table holds jobs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.head_valid == (m_data.entry_count != 5'd0)))
        else $error("Head valid disagrees with entry count.");

    // An add never removes entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_PURGED) |-> m_data.removed_count == 5'd0)
        else $error("Add reported removed entries.");

    // A dropped add means the table was full, so a head entry exists.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_FULL) |-> m_data.head_valid)
        else $error("Full status reported on an empty table.");

    // An empty head reports zero time and tag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.head_valid |-> (m_data.head_time == 32'd0)
            && (m_data.head_tag == 16'd0))
        else $error("Empty table reported a nonzero head.");

endmodule

bind time_sorted_job_table tsjt_checker u_tsjt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
